FILE: rtl/tbb_pkg.sv
`default_nettype none
package tbb_pkg;

  localparam int SAMPLE_W  = 8;
  localparam int DIAM_W    = 5;
  localparam int LOBE_W    = 4;
  localparam int COUNT_W   = 5;
  localparam int SUM_W     = 13;
  localparam int INV_W     = 15;
  localparam int SUM_SHIFT = 15;
  localparam int PROD_W    = SUM_W + INV_W;
  localparam int WIN_DEPTH = 32;
  localparam int PTR_W     = $clog2(WIN_DEPTH);
  localparam int POS_W     = 6;

  localparam logic [DIAM_W-1:0] DIAM_MIN   = DIAM_W'(2);
  localparam logic [DIAM_W-1:0] DIAM_RESET = DIAM_W'(2);

  typedef enum logic [1:0] {
    PASS_ONE,
    PASS_TWO,
    PASS_THREE
  } pass_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] val;
    logic                last;
  } item_t;

  typedef struct packed {
    logic [LOBE_W-1:0] left;
    logic [LOBE_W-1:0] right;
  } lobe_t;

  // lobe sizes of one pass for a diameter
  function automatic lobe_t lobes(input logic [DIAM_W-1:0] d, input pass_t p);
    lobe_t             lb;
    logic [LOBE_W-1:0] h;
    h = d[DIAM_W-1:1];
    lb.left  = h;
    lb.right = h;
    if (!d[0]) begin
      case (p)
        PASS_ONE:   lb.right = h - LOBE_W'(1);
        PASS_TWO:   lb.left  = h - LOBE_W'(1);
        PASS_THREE: lb.left  = h;
        default:    lb.left  = h;
      endcase
    end
    return lb;
  endfunction

  function automatic logic [COUNT_W-1:0] count_of(input lobe_t lb);
    return COUNT_W'(lb.left) + COUNT_W'(lb.right) + COUNT_W'(1);
  endfunction

  // ceil(2^15 / count)
  function automatic logic [INV_W-1:0] inv_of(input logic [COUNT_W-1:0] c);
    logic [INV_W-1:0] v;
    case (c)
      5'd2:    v = 15'd16384;
      5'd3:    v = 15'd10923;
      5'd4:    v = 15'd8192;
      5'd5:    v = 15'd6554;
      5'd6:    v = 15'd5462;
      5'd7:    v = 15'd4682;
      5'd8:    v = 15'd4096;
      5'd9:    v = 15'd3641;
      5'd10:   v = 15'd3277;
      5'd11:   v = 15'd2979;
      5'd12:   v = 15'd2731;
      5'd13:   v = 15'd2521;
      5'd14:   v = 15'd2341;
      5'd15:   v = 15'd2185;
      5'd16:   v = 15'd2048;
      5'd17:   v = 15'd1928;
      5'd18:   v = 15'd1821;
      5'd19:   v = 15'd1725;
      5'd20:   v = 15'd1639;
      5'd21:   v = 15'd1561;
      5'd22:   v = 15'd1490;
      5'd23:   v = 15'd1425;
      5'd24:   v = 15'd1366;
      5'd25:   v = 15'd1311;
      5'd26:   v = 15'd1261;
      5'd27:   v = 15'd1214;
      5'd28:   v = 15'd1171;
      5'd29:   v = 15'd1130;
      5'd30:   v = 15'd1093;
      5'd31:   v = 15'd1058;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/tbb_cell.sv
`default_nettype none
module tbb_cell (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tbb_pkg::pass_t                pass_sel,
  input  wire logic [tbb_pkg::DIAM_W-1:0]    d_in,
  output logic      [tbb_pkg::DIAM_W-1:0]    d_out,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire tbb_pkg::item_t                in_item,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output tbb_pkg::item_t                     out_item
);
  import tbb_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EMIT,
    S_FLUSH
  } state_t;

  state_t              st_r;
  logic [SAMPLE_W-1:0] win_r [WIN_DEPTH];
  logic [PTR_W-1:0]    wp_r;
  logic [SAMPLE_W-1:0] first_r;
  logic [SAMPLE_W-1:0] last_r;
  logic [POS_W-1:0]    n_r;
  logic [POS_W-1:0]    n_nxt;
  logic [SUM_W-1:0]    s_r;
  logic [LOBE_W-1:0]   i_r;
  logic [DIAM_W-1:0]   d_r;
  logic                ov_r;
  logic [SAMPLE_W-1:0] od_r;
  logic                ol_r;

  lobe_t               lb_acc;
  lobe_t               lb_run;
  logic [COUNT_W-1:0]  cnt_acc;
  logic [COUNT_W-1:0]  cnt_run;
  logic [SAMPLE_W-1:0] x;
  logic [SAMPLE_W-1:0] v_acc;
  logic [SAMPLE_W-1:0] v_fl;
  logic [COUNT_W-1:0]  off_fl;
  logic [SUM_W-1:0]    s_acc;
  logic [SUM_W-1:0]    s_fl;
  logic                emit_fl;
  logic                load_ok;
  logic                load_o;
  logic                acc;
  logic [PROD_W-1:0]   prod;
  logic [SAMPLE_W-1:0] box;

  assign x       = in_item.val;
  assign lb_acc  = lobes((n_r == '0) ? d_in : d_r, pass_sel);
  assign lb_run  = lobes(d_r, pass_sel);
  assign cnt_acc = count_of(lb_acc);
  assign cnt_run = count_of(lb_run);
  assign in_ready = (st_r == S_IDLE);
  assign acc     = in_valid && in_ready;
  assign load_ok = !ov_r || out_ready;
  assign n_nxt   = (n_r == '1) ? n_r : n_r + POS_W'(1);

  // sample leaving the window as a new one enters
  assign v_acc = (n_r < POS_W'(cnt_acc)) ? first_r : win_r[wp_r - PTR_W'(cnt_acc)];
  assign s_acc = (n_r == '0) ? SUM_W'(cnt_acc) * SUM_W'(x)
                             : s_r + SUM_W'(x) - SUM_W'(v_acc);

  // tail: window slides past the line end, padded with the last sample
  assign off_fl  = COUNT_W'(lb_run.left) + COUNT_W'(lb_run.right) - COUNT_W'(i_r);
  assign v_fl    = (n_r < POS_W'(off_fl)) ? first_r
                                          : win_r[wp_r - PTR_W'(1) - PTR_W'(off_fl)];
  assign s_fl    = s_r + SUM_W'(last_r) - SUM_W'(v_fl);
  assign emit_fl = ((POS_W+1)'(n_r) + (POS_W+1)'(i_r)) >= (POS_W+1)'(lb_run.right);

  // output register takes a new result this cycle
  assign load_o  = load_ok && ((st_r == S_EMIT) || ((st_r == S_FLUSH) && emit_fl));

  assign prod = PROD_W'(s_r) * PROD_W'(inv_of(cnt_run));
  assign box  = prod[SUM_SHIFT +: SAMPLE_W];

  always_ff @(posedge clk) begin
    if (acc) begin
      win_r[wp_r] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      ov_r    <= 1'b0;
      n_r     <= '0;
      wp_r    <= '0;
      i_r     <= '0;
      d_r     <= DIAM_RESET;
      s_r     <= '0;
      first_r <= '0;
      last_r  <= '0;
    end else begin
      if (ov_r && out_ready && !load_o) begin
        ov_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_valid) begin
            wp_r   <= wp_r + PTR_W'(1);
            s_r    <= s_acc;
            last_r <= x;
            if (n_r == '0) begin
              first_r <= x;
              d_r     <= d_in;
            end
            if (in_item.last) begin
              i_r  <= '0;
              st_r <= S_FLUSH;
            end else begin
              n_r <= n_nxt;
              if (n_r >= POS_W'(lb_acc.right)) begin
                st_r <= S_EMIT;
              end
            end
          end
        end
        S_EMIT: begin
          if (load_ok) begin
            ov_r <= 1'b1;
            od_r <= box;
            ol_r <= 1'b0;
            st_r <= S_IDLE;
          end
        end
        S_FLUSH: begin
          if (!emit_fl || load_ok) begin
            s_r <= s_fl;
            if (emit_fl) begin
              ov_r <= 1'b1;
              od_r <= box;
              ol_r <= (i_r == lb_run.right);
            end
            if (i_r == lb_run.right) begin
              st_r <= S_IDLE;
              n_r  <= '0;
            end else begin
              i_r <= i_r + LOBE_W'(1);
            end
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid    = ov_r;
  assign out_item.val  = od_r;
  assign out_item.last = ol_r;
  assign d_out        = d_r;

  a_last_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_item.last |=> st_r == S_FLUSH)
    else $error("line end did not start the tail flush");

  a_flush_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_FLUSH |-> i_r <= lb_run.right)
    else $error("flush step beyond right lobe");

  a_emit_after_lobe: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_EMIT |-> n_r > POS_W'(lb_run.right))
    else $error("output released before the right lobe filled");

endmodule
`default_nettype wire

FILE: rtl/triple_box_blur_line.sv
`default_nettype none
// three cascaded box blurs along one line of 8-bit alpha samples, a
// fixed-point stand-in for a gaussian. samples arrive in line order on the
// in_ stream, in_tlast marks the line's last pixel; blurred pixels leave in
// the same order on out_, out_tlast on the final one. the diameter register
// (2..31, lower values act as 2) sets the lobes and is picked up at the
// first sample of each line. each pass is one cell of a three-cell chain
// holding its own 32-deep window and running sum; a cell takes an item
// while idle and registers any result once its output register is free,
// and only then accepts the next sample. at line end each cell flushes
// its tail, padding the window with the line's last sample.
module triple_box_blur_line (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,   // sample[7:0]
  input  wire logic       in_tlast,   // line_end
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic      [7:0] out_tdata,  // blurred[7:0]
  output logic            out_tlast,  // is_last
  input  wire logic       cfg_we,
  input  wire logic [4:0] cfg_wdata   // diameter
);
  import tbb_pkg::*;

  logic [DIAM_W-1:0] diam_r;
  logic [DIAM_W-1:0] diam_eff;
  logic [DIAM_W-1:0] d01;
  logic [DIAM_W-1:0] d12;
  logic [DIAM_W-1:0] d2x;

  item_t in_item;
  item_t i01;
  item_t i12;
  item_t res;
  logic  v01, r01, v12, r12;

  // diameter register, clamped at the low end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diam_r <= DIAM_RESET;
    end else if (cfg_we) begin
      diam_r <= cfg_wdata;
    end
  end

  assign diam_eff = (diam_r < DIAM_MIN) ? DIAM_MIN : diam_r;

  assign in_item.val  = in_tdata;
  assign in_item.last = in_tlast;

  // pass one latches the diameter per line and hands it down the chain
  tbb_cell u_pass_one (
    .clk      (clk),
    .rst_n    (rst_n),
    .pass_sel (PASS_ONE),
    .d_in     (diam_eff),
    .d_out    (d01),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_item  (in_item),
    .out_valid(v01),
    .out_ready(r01),
    .out_item (i01)
  );

  tbb_cell u_pass_two (
    .clk      (clk),
    .rst_n    (rst_n),
    .pass_sel (PASS_TWO),
    .d_in     (d01),
    .d_out    (d12),
    .in_valid (v01),
    .in_ready (r01),
    .in_item  (i01),
    .out_valid(v12),
    .out_ready(r12),
    .out_item (i12)
  );

  tbb_cell u_pass_three (
    .clk      (clk),
    .rst_n    (rst_n),
    .pass_sel (PASS_THREE),
    .d_in     (d12),
    .d_out    (d2x),
    .in_valid (v12),
    .in_ready (r12),
    .in_item  (i12),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_item (res)
  );

  assign out_tdata = res.val;
  assign out_tlast = res.last;

  a_diam_chain_legal: assert property (@(posedge clk) disable iff (!rst_n)
    d2x >= DIAM_MIN && d12 >= DIAM_MIN)
    else $error("latched diameter below minimum");

endmodule
`default_nettype wire
